>>> rtl/core/positional_list_with_key_search_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the positional list
// Immediate-consequence and next-cycle implication checks, reset-qualified.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_WITH_KEY_SEARCH_MACROS_SVH
`define POSITIONAL_LIST_WITH_KEY_SEARCH_MACROS_SVH

// Same-cycle implication
`define PLKS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("plks: same-cycle check failed");

// Next-cycle implication
`define PLKS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("plks: next-cycle check failed");

`endif

>>> rtl/core/plks_pkg.sv
// ----------------------------------------------------------------------------
// plks_pkg
// Opcodes, status codes and the per-cell command bundle of the list.
// ----------------------------------------------------------------------------
package plks_pkg;

	localparam int OPCODE_W = 3;
	localparam int STATUS_W = 2;

	typedef enum logic [OPCODE_W-1:0] {
		OP_INSERT   = 3'd0,
		OP_APPEND   = 3'd1,
		OP_REMOVE   = 3'd2,
		OP_REM_LAST = 3'd3,
		OP_FIND     = 3'd4
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	// Checked command broadcast to every cell (at most one bit set)
	typedef struct packed {
		logic ins;
		logic app;
		logic rem;
		logic find;
	} cell_cmd_t;

endpackage

>>> rtl/core/plks_cell.sv
// ----------------------------------------------------------------------------
// plks_cell
// One list slot: holds a key and a handle, shifts from either neighbor,
// loads a new entry, and registers a key compare for find.
// ----------------------------------------------------------------------------
module plks_cell
	import plks_pkg::*;
#(
	parameter int CAPACITY    = 64,
	parameter int KEY_BITS    = 32,
	parameter int HANDLE_BITS = 16,
	parameter int INDEX       = 0
) (
	input  logic                              clk,
	input  cell_cmd_t                         cmd,
	input  logic [$clog2(CAPACITY)-1:0]       pos,
	input  logic [$clog2(CAPACITY+1)-1:0]     cnt,
	input  logic [KEY_BITS-1:0]               key_in,
	input  logic [HANDLE_BITS-1:0]            handle_in,
	input  logic [KEY_BITS-1:0]               key_left,
	input  logic [HANDLE_BITS-1:0]            handle_left,
	input  logic [KEY_BITS-1:0]               key_right,
	input  logic [HANDLE_BITS-1:0]            handle_right,
	output logic [KEY_BITS-1:0]               key,
	output logic [HANDLE_BITS-1:0]            handle,
	output logic                              hit
);

	localparam int CNT_W = $clog2(CAPACITY+1);
	localparam logic [CNT_W-1:0] IDX    = CNT_W'(INDEX);
	localparam logic [CNT_W-1:0] IDX_P1 = CNT_W'(INDEX + 1);

	logic [KEY_BITS-1:0]    key_q;
	logic [HANDLE_BITS-1:0] handle_q;
	logic                   hit_q;
	logic [CNT_W-1:0]       pos_ext;
	logic                   load_new;
	logic                   take_left;
	logic                   take_right;

	assign pos_ext = CNT_W'(pos);

	// slot decisions from own index against position and count
	assign load_new   = (cmd.ins && IDX == pos_ext) || (cmd.app && IDX == cnt);
	assign take_left  = cmd.ins && IDX > pos_ext && IDX <= cnt;
	assign take_right = cmd.rem && IDX >= pos_ext && IDX_P1 < cnt;

	// entry storage, slot holds when no move applies
	always_ff @(posedge clk) begin
		if (load_new) begin
			key_q    <= key_in;
			handle_q <= handle_in;
		end else if (take_left) begin
			key_q    <= key_left;
			handle_q <= handle_left;
		end else if (take_right) begin
			key_q    <= key_right;
			handle_q <= handle_right;
		end
	end

	// probe compare, only occupied slots can hit
	always_ff @(posedge clk) begin
		if (cmd.find) begin
			hit_q <= (IDX < cnt) && ($signed(key_in) < $signed(key_q));
		end
	end

	assign key    = key_q;
	assign handle = handle_q;
	assign hit    = hit_q;

endmodule

>>> rtl/core/plks_first_hit.sv
// ----------------------------------------------------------------------------
// plks_first_hit
// Index of the lowest set hit bit, or the entry count when none is set.
// ----------------------------------------------------------------------------
module plks_first_hit
	import plks_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic [CAPACITY-1:0]               hits,
	input  logic [$clog2(CAPACITY+1)-1:0]     cnt,
	output logic [$clog2(CAPACITY+1)-1:0]     index
);

	localparam int CNT_W = $clog2(CAPACITY+1);

	logic [CAPACITY-1:0] lowest;
	logic [CNT_W-1:0]    idx;

	// isolate the lowest set bit
	assign lowest = hits & (~hits + CAPACITY'(1));

	// one-hot to binary
	always_comb begin
		idx = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (lowest[i]) begin
				idx = idx | CNT_W'(i);
			end
		end
	end

	assign index = (|hits) ? idx : cnt;

endmodule

>>> rtl/core/positional_list_with_key_search.sv
// ----------------------------------------------------------------------------
// positional_list_with_key_search
// Ordered list with positional insert/remove and a first-greater key search.
// ----------------------------------------------------------------------------
// At the accept edge the row of entry cells shifts, loads or registers its key
// compares all at once; then, in the busy state, the first-hit encoder turns the
// compare bits into an index and the result loads into the output register once
// that register is empty or being drained. The block accepts no new
// transaction until that result has loaded. A finished result may wait
// in the output register while the next transaction is accepted and worked on.
`include "positional_list_with_key_search_macros.svh"

module positional_list_with_key_search
	import plks_pkg::*;
#(
	parameter int CAPACITY    = 64,
	parameter int KEY_BITS    = 32,
	parameter int HANDLE_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [OPCODE_W-1:0]               opcode,
	input  logic [$clog2(CAPACITY)-1:0]       position,
	input  logic [HANDLE_BITS-1:0]            entry_handle,
	input  logic [KEY_BITS-1:0]               key_value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [STATUS_W-1:0]               status,
	output logic [$clog2(CAPACITY+1)-1:0]     found_index,
	output logic [$clog2(CAPACITY+1)-1:0]     entry_count
);

	localparam int CNT_W = $clog2(CAPACITY+1);
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	typedef enum logic {
		S_IDLE,
		S_BUSY
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	status_t          pend_status_q;
	logic             pend_find_q;
	logic             out_valid_q;
	status_t          status_q;
	logic [CNT_W-1:0] found_index_q;
	logic [CNT_W-1:0] entry_count_q;

	logic             in_fire;
	logic             full;
	logic             empty;
	logic             pos_bad;
	cell_cmd_t        cmd;
	cell_cmd_t        cell_cmd;
	status_t          st_next;
	logic [CNT_W-1:0] cnt_next;
	logic [CNT_W-1:0] found_w;

	logic [KEY_BITS-1:0]    keys    [CAPACITY];
	logic [HANDLE_BITS-1:0] handles [CAPACITY];
	logic [CAPACITY-1:0]    hits;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;

	assign full    = (cnt_q == CAP_CNT);
	assign empty   = (cnt_q == '0);
	assign pos_bad = (CNT_W'(position) >= cnt_q);

	// command check and next count
	always_comb begin
		cmd      = '0;
		st_next  = ST_DONE;
		cnt_next = cnt_q;
		unique case (opcode)
			OP_INSERT: begin
				if (full) begin
					st_next = ST_FULL;
				end else if (empty && position == '0) begin
					cmd.ins  = 1'b1;
					cnt_next = cnt_q + CNT_W'(1);
				end else if (pos_bad) begin
					st_next = ST_RANGE;
				end else begin
					cmd.ins  = 1'b1;
					cnt_next = cnt_q + CNT_W'(1);
				end
			end
			OP_APPEND: begin
				if (full) begin
					st_next = ST_FULL;
				end else begin
					cmd.app  = 1'b1;
					cnt_next = cnt_q + CNT_W'(1);
				end
			end
			OP_REMOVE: begin
				if (empty) begin
					st_next = ST_EMPTY;
				end else if (pos_bad) begin
					st_next = ST_RANGE;
				end else begin
					cmd.rem  = 1'b1;
					cnt_next = cnt_q - CNT_W'(1);
				end
			end
			OP_REM_LAST: begin
				if (empty) begin
					st_next = ST_EMPTY;
				end else begin
					cnt_next = cnt_q - CNT_W'(1);
				end
			end
			OP_FIND: begin
				cmd.find = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	assign cell_cmd = in_fire ? cmd : '0;

	// row of entry cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [KEY_BITS-1:0]    key_l;
		logic [HANDLE_BITS-1:0] handle_l;
		logic [KEY_BITS-1:0]    key_r;
		logic [HANDLE_BITS-1:0] handle_r;

		if (i == 0) begin : g_first
			assign key_l    = key_value;
			assign handle_l = entry_handle;
		end else begin : g_mid_l
			assign key_l    = keys[i-1];
			assign handle_l = handles[i-1];
		end

		if (i == CAPACITY-1) begin : g_last
			assign key_r    = keys[i];
			assign handle_r = handles[i];
		end else begin : g_mid_r
			assign key_r    = keys[i+1];
			assign handle_r = handles[i+1];
		end

		plks_cell #(
			.CAPACITY    (CAPACITY),
			.KEY_BITS    (KEY_BITS),
			.HANDLE_BITS (HANDLE_BITS),
			.INDEX       (i)
		) u_cell (
			.clk          (clk),
			.cmd          (cell_cmd),
			.pos          (position),
			.cnt          (cnt_q),
			.key_in       (key_value),
			.handle_in    (entry_handle),
			.key_left     (key_l),
			.handle_left  (handle_l),
			.key_right    (key_r),
			.handle_right (handle_r),
			.key          (keys[i]),
			.handle       (handles[i]),
			.hit          (hits[i])
		);
	end

	// first greater key
	plks_first_hit #(
		.CAPACITY (CAPACITY)
	) u_first_hit (
		.hits  (hits),
		.cnt   (cnt_q),
		.index (found_w)
	);

	// control and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cnt_q         <= '0;
			pend_status_q <= ST_DONE;
			pend_find_q   <= 1'b0;
			out_valid_q   <= 1'b0;
			status_q      <= ST_DONE;
			found_index_q <= '0;
			entry_count_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
					end
					if (in_valid) begin
						state_q       <= S_BUSY;
						cnt_q         <= cnt_next;
						pend_status_q <= st_next;
						pend_find_q   <= cmd.find;
					end
				end
				S_BUSY: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q   <= 1'b1;
						status_q      <= pend_status_q;
						found_index_q <= pend_find_q ? found_w : '0;
						entry_count_q <= cnt_q;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign found_index = found_index_q;
	assign entry_count = entry_count_q;

	// checks
	`PLKS_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CAP_CNT)
	`PLKS_ASSERT_NXT(a_accept_busy, clk, arst_n, in_fire, state_q == S_BUSY)
	`PLKS_ASSERT_NXT(a_cnt_only_on_accept, clk, arst_n, !in_fire, $stable(cnt_q))
	`PLKS_ASSERT_NXT(a_busy_drains, clk, arst_n,
		state_q == S_BUSY && (!out_valid_q || out_ready), out_valid_q && state_q == S_IDLE)
	`PLKS_ASSERT_IMP(a_found_le_cnt, clk, arst_n, out_valid_q, found_index_q <= entry_count_q)

endmodule
